[hw/rtl/dcr_pkg.sv]
// Package for the damped comb resonator: register indexes, constants, tanh table.
// No dependencies.
`default_nettype none
package dcr_pkg;
  localparam int DefaultDepth = 4096;
  localparam int SampleW = 24;
  localparam int CfgW = 20;
  localparam int CfgIdxW = 3;
  localparam logic [2:0] REG_DELAY = 3'd0;
  localparam logic [2:0] REG_FB = 3'd1;
  localparam logic [2:0] REG_DAMP = 3'd2;
  localparam logic [2:0] REG_POL = 3'd3;
  localparam logic [2:0] REG_DCB = 3'd4;
  localparam logic [2:0] REG_GATE = 3'd5;
  localparam logic [2:0] REG_DECAY = 3'd6;
  localparam logic [2:0] REG_GAIN = 3'd7;
  localparam logic [23:0] AttackQ24 = 24'd838861;
  localparam logic [23:0] ReleaseQ24 = 24'd3355;
  localparam logic [15:0] BiasQ16 = 16'd42598;
  localparam logic [24:0] GateFloor = 25'd9;
  localparam logic [24:0] GateOffset = 25'd8389;

  function automatic logic [22:0] tanh_tab(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0: r = 23'd0;        5'd1: r = 23'd1043149;  5'd2: r = 23'd2054529;
      5'd3: r = 23'd3006116;  5'd4: r = 23'd3876518;  5'd5: r = 23'd4652322;
      5'd6: r = 23'd5328016;  5'd7: r = 23'd5904792;  5'd8: r = 23'd6388713;
      5'd9: r = 23'd6788909;  5'd10: r = 23'd7115922; 5'd11: r = 23'd7380524;
      5'd12: r = 23'd7592932; 5'd13: r = 23'd7762364; 5'd14: r = 23'd7896834;
      5'd15: r = 23'd8003110; default: r = 23'd8086853;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/damped_comb_resonator_top.sv]
// Top level of the damped comb resonator: sequencer, delay memory, state.
// Depends on dcr_pkg, dcr_serial_mul and dcr_serial_div.
//
// Usage: one input item (in_sample, in_channel) is taken when in_valid is
// high and in_stall low; one result item (out_sample, out_channel) follows
// on the output channel, held while out_stall is high.
// Items are processed one at a time. A bit-serial multiplier, reused for
// every product of the datapath, sets the cost: five products per item
// (four when the tanh input saturates), two more with the DC bias, and with
// the peak gate up to two more plus a serial divide. out_valid rises as the
// sequencer returns to idle, ready for the next accept.
// A new item is accepted once the previous result is in the output
// register, even while that result is still stalled; its own result then
// waits until that register is free.
// After reset a clearing pass writes zero through all 2*DELAY_DEPTH entries
// of the delay memory, one entry a cycle, during which no item is accepted;
// configuration writes are taken at any time.
// Registers are written with cfg_we, cfg_index and cfg_data.
`default_nettype none
module damped_comb_resonator_top #(
  parameter int DELAY_DEPTH = dcr_pkg::DefaultDepth
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [23:0]         in_sample,
  input  wire logic                       in_channel,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [23:0]              out_sample,
  output logic                            out_channel,
  input  wire logic                       cfg_we,
  input  wire logic [dcr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dcr_pkg::CfgW-1:0]   cfg_data
);
  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int MW = AW + 1;
  localparam int MAXD = (DELAY_DEPTH - 2) * 256;
  localparam int DLW = (MAXD > 1048575) ? 1 : 0;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ADDR, S_RD1, S_RD2, S_INTERP, S_INTERP_W, S_LPF, S_LPF_W,
    S_FB, S_FB_W, S_SUM, S_TANH, S_TANH_W, S_WB, S_DCB, S_DCB_W, S_BIAS, S_BIAS_W,
    S_GATE, S_DECAY_W, S_GDIV, S_GDIV_W, S_GAIN, S_GAIN_W, S_OUT
  } state_t;

  state_t state;
  logic [19:0] delay_length;
  logic [15:0] feedback_gain, damping_coeff, peak_decay_coeff, output_gain;
  logic polarity_mode, dc_bias_on, peak_gate_on;

  logic signed [23:0] mem [2*DELAY_DEPTH];
  logic [MW-1:0] maddr;
  logic signed [23:0] mrd;
  logic mwe;
  logic signed [23:0] mwd;

  logic [AW-1:0] wpos [2];
  logic signed [23:0] damp [2];
  logic signed [23:0] benv [2];
  logic [24:0] penv [2];

  logic ch;
  logic signed [23:0] x;
  logic [AW-1:0] idx1;
  logic [7:0] wgt;
  logic signed [23:0] s1;
  logic signed [39:0] acc;
  logic signed [25:0] ysum;
  logic signed [24:0] o;
  logic [24:0] amag, e;
  logic [MW-1:0] clr;

  logic mstart, mdone;
  logic signed [39:0] ma;
  logic signed [24:0] mb;
  logic signed [64:0] mp;
  logic dstart, ddone;
  logic [49:0] dq;

  logic [20:0] d;
  logic [AW-1:0] dint;
  logic [24:0] tm;
  logic signed [24:0] y;

  dcr_serial_mul #(.AW(40), .BW(25)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
  );
  dcr_serial_div #(.NW(50), .DW(26)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .n(mp[49:0]),
    .d({1'b0, e} + {1'b0, dcr_pkg::GateOffset}), .done(ddone), .q(dq)
  );

  always_comb begin
    if (!polarity_mode) begin
      d = {1'b0, delay_length};
      if (d < 21'd512) d = 21'd512;
      if (DLW == 0 && d > 21'(MAXD)) d = 21'(MAXD);
    end else begin
      d = {2'b0, delay_length[19:1]};
      if (d < 21'd256) d = 21'd256;
    end
    dint = AW'(d >> 8);
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd <= mem[maddr];
  end

  assign in_stall = (state != S_IDLE);
  assign tm = ysum[25] ? 25'(-ysum) : 25'(ysum);
  assign y = acc[24:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      mstart <= 1'b0;
      dstart <= 1'b0;
      mwe <= 1'b0;
      delay_length <= 20'd46976;
      feedback_gain <= 16'd64704;
      damping_coeff <= 16'd53215;
      polarity_mode <= 1'b0;
      dc_bias_on <= 1'b0;
      peak_gate_on <= 1'b0;
      peak_decay_coeff <= 16'd64704;
      output_gain <= 16'd16384;
      for (int i = 0; i < 2; i++) begin
        wpos[i] <= '0; damp[i] <= '0; benv[i] <= '0; penv[i] <= '0;
      end
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      mwe <= 1'b0;
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          dcr_pkg::REG_DELAY: delay_length <= cfg_data;
          dcr_pkg::REG_FB:    feedback_gain <= cfg_data[15:0];
          dcr_pkg::REG_DAMP:  damping_coeff <= cfg_data[15:0];
          dcr_pkg::REG_POL:   polarity_mode <= cfg_data[0];
          dcr_pkg::REG_DCB:   dc_bias_on <= cfg_data[0];
          dcr_pkg::REG_GATE:  peak_gate_on <= cfg_data[0];
          dcr_pkg::REG_DECAY: peak_decay_coeff <= cfg_data[15:0];
          dcr_pkg::REG_GAIN:  output_gain <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          maddr <= clr;
          mwd <= '0;
          mwe <= 1'b1;
          clr <= clr + 1'b1;
          if (clr == MW'(2*DELAY_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          x <= in_sample;
          ch <= in_channel;
          state <= S_ADDR;
        end
        S_ADDR: begin
          idx1 <= wpos[ch] - dint - AW'(d[7:0] != 8'd0);
          wgt <= (d[7:0] != 8'd0) ? 8'(9'd256 - {1'b0, d[7:0]}) : 8'd0;
          maddr <= {ch, wpos[ch] - dint - AW'(d[7:0] != 8'd0)};
          state <= S_RD1;
        end
        S_RD1: begin
          maddr <= {ch, idx1 + 1'b1};
          state <= S_RD2;
        end
        S_RD2: begin
          s1 <= mrd;
          state <= S_INTERP;
        end
        S_INTERP: begin
          ma <= 40'(mrd) - 40'(s1);
          mb <= {16'd0, 1'b0, wgt};
          mstart <= 1'b1;
          state <= S_INTERP_W;
        end
        S_INTERP_W: if (mdone) begin
          acc <= 40'(s1) + 40'(mp >>> 8);
          state <= S_LPF;
        end
        S_LPF: begin
          ma <= acc - 40'(damp[ch]);
          mb <= {9'd0, damping_coeff};
          mstart <= 1'b1;
          state <= S_LPF_W;
        end
        S_LPF_W: if (mdone) begin
          damp[ch] <= 24'(40'(damp[ch]) + 40'(mp >>> 16));
          ma <= 40'(damp[ch]) + 40'(mp >>> 16);
          state <= S_FB;
        end
        S_FB: begin
          mb <= {9'd0, feedback_gain};
          mstart <= 1'b1;
          state <= S_FB_W;
        end
        S_FB_W: if (mdone) begin
          ysum <= polarity_mode ? 26'(x) - 26'(mp >>> 16) : 26'(x) + 26'(mp >>> 16);
          state <= S_SUM;
        end
        S_SUM: begin
          if (tm >= 25'(16 << 20)) begin
            acc <= 40'(dcr_pkg::tanh_tab(5'd16));
            state <= S_WB;
          end else begin
            acc <= 40'(dcr_pkg::tanh_tab(tm[24:20]));
            ma <= 40'(dcr_pkg::tanh_tab(tm[24:20] + 1'b1))
                - 40'(dcr_pkg::tanh_tab(tm[24:20]));
            mb <= {4'd0, 1'b0, tm[19:0]};
            mstart <= 1'b1;
            state <= S_TANH_W;
          end
        end
        S_TANH_W: if (mdone) begin
          acc <= acc + 40'(mp >>> 20);
          state <= S_TANH;
        end
        S_TANH: begin
          if (ysum[25]) acc <= -acc;
          state <= S_WB;
        end
        S_WB: begin
          if (ysum[25] && state == S_WB && acc > 0 && tm >= 25'(16 << 20)) acc <= -acc;
          state <= S_DCB;
        end
        S_DCB: begin
          maddr <= {ch, wpos[ch]};
          mwd <= y[23:0];
          mwe <= 1'b1;
          wpos[ch] <= wpos[ch] + 1'b1;
          o <= y;
          amag <= y[24] ? -y : y;
          if (dc_bias_on) begin
            ma <= 40'($signed({1'b0, y[24] ? -y : y})) - 40'(benv[ch]);
            mb <= ((y[24] ? -y : y) > 25'(benv[ch])) ? {1'b0, dcr_pkg::AttackQ24}
                                                    : {1'b0, dcr_pkg::ReleaseQ24};
            mstart <= 1'b1;
            state <= S_DCB_W;
          end else state <= S_GATE;
        end
        S_DCB_W: if (mdone) begin
          benv[ch] <= 24'(40'(benv[ch]) + 40'(mp >>> 24));
          ma <= 40'(benv[ch]) + 40'(mp >>> 24);
          mb <= {9'd0, dcr_pkg::BiasQ16};
          mstart <= 1'b1;
          state <= S_BIAS_W;
        end
        S_BIAS_W: if (mdone) begin
          o <= o + 25'(mp >>> 16);
          state <= S_BIAS;
        end
        S_BIAS: state <= S_GATE;
        S_GATE: begin
          amag <= o[24] ? -o : o;
          if (!peak_gate_on) state <= S_GAIN;
          else if ((o[24] ? -o : o) > penv[ch]) begin
            e <= o[24] ? -o : o;
            state <= S_DECAY_W;
          end else begin
            ma <= 40'(penv[ch]);
            mb <= {9'd0, peak_decay_coeff};
            mstart <= 1'b1;
            e <= '1;
            state <= S_DECAY_W;
          end
        end
        S_DECAY_W: if (e != '1 || mdone) begin
          if (e == '1) begin
            e <= (25'(mp >>> 16) < dcr_pkg::GateFloor) ? '0 : 25'(mp >>> 16);
            penv[ch] <= (25'(mp >>> 16) < dcr_pkg::GateFloor) ? '0 : 25'(mp >>> 16);
          end else begin
            e <= (e < dcr_pkg::GateFloor) ? '0 : e;
            penv[ch] <= (e < dcr_pkg::GateFloor) ? '0 : e;
          end
          state <= S_GDIV;
        end
        S_GDIV: begin
          if (e == '0) begin
            o <= '0;
            state <= S_GAIN;
          end else begin
            ma <= 40'(amag);
            mb <= e;
            mstart <= 1'b1;
            state <= S_GDIV_W;
          end
        end
        S_GDIV_W: begin
          if (mdone) dstart <= 1'b1;
          if (ddone) begin
            o <= o[24] ? -25'(dq) : 25'(dq);
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          ma <= 40'(o);
          mb <= {9'd0, output_gain};
          mstart <= 1'b1;
          state <= S_GAIN_W;
        end
        S_GAIN_W: if (mdone) begin
          acc <= 40'(mp >>> 17);
          state <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_channel <= ch;
          if (acc > 40'sd8388607) out_sample <= 24'sd8388607;
          else if (acc < -40'sd8388608) out_sample <= -24'sd8388608;
          else out_sample <= acc[23:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(mstart && dstart)) else $error("units collide");
`endif
endmodule
`default_nettype wire

[hw/rtl/dcr_serial_mul.sv]
// Bit-serial signed multiplier: shift-add one multiplier bit per cycle.
// Depends on nothing.
`default_nettype none
module dcr_serial_mul #(
  parameter int AW = 40,
  parameter int BW = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic                      done,
  output logic signed [AW+BW-1:0]   p
);
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc <= '0;
        mcand <= (AW+BW)'(a);
        mplier <= b;
        cnt <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          if (cnt == CW'(BW - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign p = acc;
endmodule
`default_nettype wire

[hw/rtl/dcr_serial_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing.
`default_nettype none
module dcr_serial_div #(
  parameter int NW = 50,
  parameter int DW = 26
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] n,
  input  wire logic [DW-1:0] d,
  output logic               done,
  output logic [NW-1:0]      q
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0] rem;
  logic [DW:0] trial;
  logic [NW-1:0] num;
  logic [CW-1:0] cnt;
  logic busy;

  assign trial = {rem[DW-1:0], num[NW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        num <= n;
        cnt <= '0;
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial;
          num <= {num[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-1:0], num[NW-1]};
          num <= {num[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign q = num;
endmodule
`default_nettype wire
